### rtl/core/fbob_pkg.sv
// shared constants and codes for the frame bounce overlay blend block
`default_nettype none

package fbob_pkg;

  // default sizes of the frame store
  localparam int MAX_FRAMES_DEF  = 16;
  localparam int LUMA_PIXELS_DEF = 4096;

  // field widths
  localparam int PLANE_W    = 2;
  localparam int POS_W      = 12;
  localparam int SAMPLE_W   = 8;
  localparam int SPAN_W     = 4;
  localparam int S_TDATA_W  = 24;
  localparam int M_TDATA_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // plane codes
  localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
  localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
  localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WRAP    = 2'd2;

  // register reset values
  localparam logic [SAMPLE_W-1:0] OPACITY_RST = 8'd150;
  localparam logic [SPAN_W-1:0]   SPAN_RST    = 4'd8;
  localparam logic                WRAP_RST    = 1'b1;

  // store clear values and blend full scale
  localparam logic [SAMPLE_W-1:0] LUMA_BLACK  = 8'd16;
  localparam logic [SAMPLE_W-1:0] CHROMA_MID  = 8'd128;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE  = 8'd255;

  // fixed point shift for the reciprocal used in the position modulo
  localparam int RECIP_SHIFT = 24;

endpackage

`default_nettype wire

### rtl/core/frame_bounce_overlay_blend.sv
// top level of the frame bounce overlay blend block
`default_nettype none

// Takes one YUV 4:2:0 sample per clock and gives one result per sample, passing
// through the input register, the memory read and the output register; the
// sustained rate is one sample per clock while the result side does not stall,
// set by the single read and single write port of each sample memory, with the
// write of a blended value forwarded to a sample that reads the same entry in the
// same cycle. Luma lives in one memory and both chroma planes in another, each
// indexed by frame slot and position. After reset a clearing pass fills the
// memories with black luma and neutral chroma, one entry per cycle, while
// s_axis_tready stays low; configuration writes are taken at any time.
module frame_bounce_overlay_blend #(
  parameter int MAX_FRAMES  = fbob_pkg::MAX_FRAMES_DEF,
  parameter int LUMA_PIXELS = fbob_pkg::LUMA_PIXELS_DEF
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // input samples
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  wire  [fbob_pkg::S_TDATA_W-1:0]       s_axis_tdata,   // position[11:0], sample[19:12]
  input  wire  [fbob_pkg::PLANE_W-1:0]         s_axis_tuser,   // plane[1:0]
  input  wire                                  s_axis_tlast,   // frame_end
  // result samples
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  output logic [fbob_pkg::M_TDATA_W-1:0]       m_axis_tdata,   // out_sample[7:0]
  output logic [fbob_pkg::PLANE_W-1:0]         m_axis_tuser,   // out_plane[1:0]
  output logic                                 m_axis_tlast,   // out_frame_end
  // register writes
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [fbob_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [fbob_pkg::CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int POS_W    = fbob_pkg::POS_W;
  localparam int SMP_W    = fbob_pkg::SAMPLE_W;
  localparam int PL_W     = fbob_pkg::PLANE_W;
  localparam int SLOT_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int SPAN_MW  = $clog2(MAX_FRAMES + 1);
  localparam int SCMP_W   = (SPAN_MW > fbob_pkg::SPAN_W) ? SPAN_MW : fbob_pkg::SPAN_W;
  localparam int CHROMA_PIXELS = LUMA_PIXELS / 4;
  localparam int LIDX_W   = $clog2(LUMA_PIXELS);
  localparam int CIDX_W   = (LIDX_W > 2) ? LIDX_W - 2 : 1;
  localparam int LADDR_W  = SLOT_W + LIDX_W;
  localparam int CADDR_W  = SLOT_W + 1 + CIDX_W;
  localparam int LDEPTH   = MAX_FRAMES << LIDX_W;
  localparam int CDEPTH   = MAX_FRAMES << (CIDX_W + 1);
  localparam int CLR_DEPTH = (LDEPTH > CDEPTH) ? LDEPTH : CDEPTH;
  localparam int CLR_W    = $clog2(CLR_DEPTH);
  localparam int CLR_CW   = CLR_W + 1;
  localparam int RSH      = fbob_pkg::RECIP_SHIFT;
  localparam int RECIP_L  = (1 << RSH) / LUMA_PIXELS;
  localparam int RECIP_C  = (1 << RSH) / CHROMA_PIXELS;
  localparam int PROD_W   = 40;

  // ---------------------------------------------------------------------------
  // configuration registers
  logic [SMP_W-1:0]              opacity_q;
  logic [fbob_pkg::SPAN_W-1:0]   span_q;
  logic                          wrap_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= fbob_pkg::OPACITY_RST;
      span_q    <= fbob_pkg::SPAN_RST;
      wrap_q    <= fbob_pkg::WRAP_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fbob_pkg::CFG_OPACITY: opacity_q <= cfg_data_i;
        fbob_pkg::CFG_SPAN:    span_q    <= cfg_data_i[fbob_pkg::SPAN_W-1:0];
        fbob_pkg::CFG_WRAP:    wrap_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // clearing pass after reset
  logic             clearing_q;
  logic [CLR_W-1:0] clr_q;
  logic             clr_l;
  logic             clr_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_q      <= '0;
    end else if (clearing_q) begin
      clr_q <= clr_q + 1'b1;
      if (clr_q == CLR_W'(CLR_DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  assign clr_l = clearing_q && ({1'b0, clr_q} < CLR_CW'(LDEPTH));
  assign clr_c = clearing_q && ({1'b0, clr_q} < CLR_CW'(CDEPTH));

  // ---------------------------------------------------------------------------
  // pipeline handshake
  logic va_q, vb_q, vo_q;
  logic en_a, en_b, en_o;
  logic in_acc;

  assign en_o          = !vo_q || m_axis_tready;
  assign en_b          = !vb_q || en_o;
  assign en_a          = !va_q || en_b;
  assign s_axis_tready = en_a && !clearing_q;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // slot sequencing on frame end
  logic [SLOT_W-1:0] slot_q;
  logic              rev_q;
  logic [SCMP_W-1:0] span_eff;
  logic [SCMP_W-1:0] slot_nxt;
  logic              rev_nxt;

  always_comb begin
    if (span_q == '0) begin
      span_eff = SCMP_W'(1);
    end else if (SCMP_W'(span_q) > SCMP_W'(MAX_FRAMES)) begin
      span_eff = SCMP_W'(MAX_FRAMES);
    end else begin
      span_eff = SCMP_W'(span_q);
    end
    rev_nxt = rev_q;
    if (rev_q) begin
      slot_nxt = (slot_q != '0) ? SCMP_W'(slot_q) - 1'b1 : SCMP_W'(slot_q);
    end else begin
      slot_nxt = SCMP_W'(slot_q) + 1'b1;
    end
    if (slot_nxt >= span_eff) begin
      if (wrap_q) begin
        slot_nxt = '0;
      end else begin
        rev_nxt  = 1'b1;
        slot_nxt = span_eff - 1'b1;
      end
    end
    if (slot_nxt == '0) begin
      rev_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      rev_q  <= 1'b0;
    end else if (in_acc && s_axis_tlast) begin
      slot_q <= slot_nxt[SLOT_W-1:0];
      rev_q  <= rev_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // stage a: input register with reciprocal quotient estimates
  logic [PROD_W-1:0] prod_l, prod_c;
  logic [PL_W-1:0]   a_plane_q;
  logic [POS_W-1:0]  a_pos_q;
  logic [POS_W-1:0]  a_ql_q, a_qc_q;
  logic [SMP_W-1:0]  a_smp_q;
  logic              a_fe_q;
  logic [SLOT_W-1:0] a_slot_q;
  logic              a_rev_q;

  assign prod_l = PROD_W'(s_axis_tdata[POS_W-1:0]) * PROD_W'(RECIP_L);
  assign prod_c = PROD_W'(s_axis_tdata[POS_W-1:0]) * PROD_W'(RECIP_C);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
    end else if (en_a) begin
      va_q <= in_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      a_plane_q <= s_axis_tuser;
      a_pos_q   <= s_axis_tdata[POS_W-1:0];
      a_smp_q   <= s_axis_tdata[POS_W +: SMP_W];
      a_fe_q    <= s_axis_tlast;
      a_ql_q    <= prod_l[RSH +: POS_W];
      a_qc_q    <= prod_c[RSH +: POS_W];
      a_slot_q  <= slot_q;
      a_rev_q   <= rev_q;
    end
  end

  // position remainders with one correction step, then memory addresses
  logic [31:0]        rl, rc, rl_fix, rc_fix;
  logic [LADDR_W-1:0] a_laddr;
  logic [CADDR_W-1:0] a_caddr;

  always_comb begin
    rl     = 32'(a_pos_q) - 32'(a_ql_q) * 32'(LUMA_PIXELS);
    rc     = 32'(a_pos_q) - 32'(a_qc_q) * 32'(CHROMA_PIXELS);
    rl_fix = (rl >= 32'(LUMA_PIXELS))   ? rl - 32'(LUMA_PIXELS)   : rl;
    rc_fix = (rc >= 32'(CHROMA_PIXELS)) ? rc - 32'(CHROMA_PIXELS) : rc;
  end

  assign a_laddr = {a_slot_q, rl_fix[LIDX_W-1:0]};
  assign a_caddr = {a_slot_q, a_plane_q == fbob_pkg::PLANE_V, rc_fix[CIDX_W-1:0]};

  // ---------------------------------------------------------------------------
  // stage b: read data arrives, blend and write back
  logic [PL_W-1:0]    b_plane_q;
  logic [SMP_W-1:0]   b_smp_q;
  logic               b_fe_q;
  logic               b_slot0_q;
  logic               b_rev_q;
  logic [LADDR_W-1:0] b_laddr_q;
  logic [CADDR_W-1:0] b_caddr_q;
  logic               b_fwd_q;
  logic [SMP_W-1:0]   b_fwd_data_q;
  logic [SMP_W-1:0]   l_rdata_q, c_rdata_q;

  logic               b_is_l, b_is_c, b_store;
  logic               b_wr_l, b_wr_c;
  logic [SMP_W-1:0]   stored, blend, b_wdata, b_result;
  logic [15:0]        blend_sum;
  logic               rd_en, fwd_d;

  always_comb begin
    b_is_l    = b_plane_q == fbob_pkg::PLANE_Y;
    b_is_c    = (b_plane_q == fbob_pkg::PLANE_U) || (b_plane_q == fbob_pkg::PLANE_V);
    stored    = b_fwd_q ? b_fwd_data_q : (b_is_l ? l_rdata_q : c_rdata_q);
    blend_sum = 16'(SMP_W'(fbob_pkg::FULL_SCALE - opacity_q)) * 16'(b_smp_q)
              + 16'(opacity_q) * 16'(stored);
    blend     = blend_sum[15:8];
    b_store   = b_slot0_q || !b_rev_q;
    b_wdata   = b_slot0_q ? b_smp_q : blend;
    b_wr_l    = vb_q && en_o && b_is_l && b_store;
    b_wr_c    = vb_q && en_o && b_is_c && b_store;
    if (!(b_is_l || b_is_c) || b_slot0_q) begin
      b_result = b_smp_q;
    end else if (!b_rev_q) begin
      b_result = blend;
    end else begin
      b_result = stored;
    end
  end

  // forward a write that lands on the entry read in the same cycle
  assign rd_en = va_q && en_b;

  always_comb begin
    if (a_plane_q == fbob_pkg::PLANE_Y) begin
      fwd_d = b_wr_l && (b_laddr_q == a_laddr);
    end else if ((a_plane_q == fbob_pkg::PLANE_U) || (a_plane_q == fbob_pkg::PLANE_V)) begin
      fwd_d = b_wr_c && (b_caddr_q == a_caddr);
    end else begin
      fwd_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
    end else if (en_b) begin
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      b_plane_q    <= a_plane_q;
      b_smp_q      <= a_smp_q;
      b_fe_q       <= a_fe_q;
      b_slot0_q    <= a_slot_q == '0;
      b_rev_q      <= a_rev_q;
      b_laddr_q    <= a_laddr;
      b_caddr_q    <= a_caddr;
      b_fwd_q      <= fwd_d;
      b_fwd_data_q <= b_wdata;
    end
  end

  // ---------------------------------------------------------------------------
  // sample memories
  logic [SMP_W-1:0] luma_mem   [LDEPTH];
  logic [SMP_W-1:0] chroma_mem [CDEPTH];

  logic               l_we, c_we;
  logic [LADDR_W-1:0] l_waddr;
  logic [CADDR_W-1:0] c_waddr;
  logic [SMP_W-1:0]   l_wdata, c_wdata;

  always_comb begin
    if (clearing_q) begin
      l_we    = clr_l;
      c_we    = clr_c;
      l_waddr = clr_q[LADDR_W-1:0];
      c_waddr = clr_q[CADDR_W-1:0];
      l_wdata = fbob_pkg::LUMA_BLACK;
      c_wdata = fbob_pkg::CHROMA_MID;
    end else begin
      l_we    = b_wr_l;
      c_we    = b_wr_c;
      l_waddr = b_laddr_q;
      c_waddr = b_caddr_q;
      l_wdata = b_wdata;
      c_wdata = b_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (l_we) begin
      luma_mem[l_waddr] <= l_wdata;
    end
    if (rd_en) begin
      l_rdata_q <= luma_mem[a_laddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      chroma_mem[c_waddr] <= c_wdata;
    end
    if (rd_en) begin
      c_rdata_q <= chroma_mem[a_caddr];
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  logic [SMP_W-1:0] o_smp_q;
  logic [PL_W-1:0]  o_plane_q;
  logic             o_fe_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en_o) begin
      vo_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o && vb_q) begin
      o_smp_q   <= b_result;
      o_plane_q <= b_plane_q;
      o_fe_q    <= b_fe_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = o_smp_q;
  assign m_axis_tuser  = o_plane_q;
  assign m_axis_tlast  = o_fe_q;

endmodule

`default_nettype wire

### rtl/core/fbob_chk.sv
// port-level checker for the frame bounce overlay blend block, with its bind
`default_nettype none

module fbob_chk (
  input wire                               clk_i,
  input wire                               rst_ni,
  input wire                               s_axis_tvalid,
  input wire                               s_axis_tready,
  input wire                               m_axis_tvalid,
  input wire                               m_axis_tready,
  input wire [fbob_pkg::M_TDATA_W-1:0]     m_axis_tdata,
  input wire [fbob_pkg::PLANE_W-1:0]       m_axis_tuser,
  input wire                               m_axis_tlast,
  input wire                               cfg_valid_i,
  input wire                               cfg_ready_o
);

  // requests taken in but not yet given out
  logic [2:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_q + {2'b00, in_acc} - {2'b00, out_acc};
    end
  end

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result payload changed while stalled");

  // no result without a request in flight
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pend_q != 3'd0)
    else $error("result without pending request");

  // at most three requests in flight
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'd3)
    else $error("more requests in flight than pipeline stages");

  // configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind frame_bounce_overlay_blend fbob_chk u_fbob_chk (.*);

`default_nettype wire

### tb/tb_frame_bounce_overlay_blend.sv
// self-checking testbench for the frame bounce overlay blend block
`timescale 1ns / 1ps

module tb_frame_bounce_overlay_blend;

  localparam int CHROMA_PIXELS = fbob_pkg::LUMA_PIXELS_DEF / 4;
  localparam int HALF_PERIOD   = 6;
  localparam logic [fbob_pkg::PLANE_W-1:0]   PLANE_NONE = 2'd3;
  localparam logic [fbob_pkg::CFG_IDX_W-1:0] CFG_NONE   = 2'd3;

  typedef struct packed {
    logic [fbob_pkg::PLANE_W-1:0]  plane;
    logic [fbob_pkg::POS_W-1:0]    position;
    logic [fbob_pkg::SAMPLE_W-1:0] sample;
    logic                          frame_end;
  } pixel_req_t;

  typedef struct packed {
    logic [fbob_pkg::SAMPLE_W-1:0] sample;
    logic [fbob_pkg::PLANE_W-1:0]  plane;
    logic                          frame_end;
  } pixel_res_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // block ports
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [fbob_pkg::S_TDATA_W-1:0]  s_axis_tdata  = '0;  // position[11:0], sample[19:12]
  logic [fbob_pkg::PLANE_W-1:0]    s_axis_tuser  = '0;  // plane[1:0]
  logic                            s_axis_tlast  = 1'b0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [fbob_pkg::M_TDATA_W-1:0]  m_axis_tdata;        // out_sample[7:0]
  logic [fbob_pkg::PLANE_W-1:0]    m_axis_tuser;        // out_plane[1:0]
  logic                            m_axis_tlast;
  logic                            cfg_valid_i   = 1'b0;
  logic                            cfg_ready_o;
  logic [fbob_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [fbob_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  frame_bounce_overlay_blend dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // shadow of the frame store, slot tracking and registers
  logic [fbob_pkg::SAMPLE_W-1:0] luma_mem [fbob_pkg::MAX_FRAMES_DEF*fbob_pkg::LUMA_PIXELS_DEF];
  logic [fbob_pkg::SAMPLE_W-1:0] cb_mem   [fbob_pkg::MAX_FRAMES_DEF*CHROMA_PIXELS];
  logic [fbob_pkg::SAMPLE_W-1:0] cr_mem   [fbob_pkg::MAX_FRAMES_DEF*CHROMA_PIXELS];
  int   cur_slot;
  logic reversing;
  int   cur_opacity;
  int   cur_span;
  logic cur_wrap;

  pixel_req_t send_pixels[$];
  pixel_res_t expected_pixels[$];

  int n_queued, n_accepted, n_results, n_errors;
  int n_frame_ends, n_blends, n_replays, n_cfg_writes;
  int sender_idle_max, sink_stall_max;

  // step the frame slot on a frame end: wrap or bounce at the end of the span
  function automatic void advance_slot();
    int span_eff;
    span_eff = (cur_span < 1) ? 1 : cur_span;
    if (span_eff > fbob_pkg::MAX_FRAMES_DEF) span_eff = fbob_pkg::MAX_FRAMES_DEF;
    if (reversing) begin
      if (cur_slot > 0) cur_slot--;
    end else begin
      cur_slot++;
    end
    if (cur_slot >= span_eff) begin
      if (!cur_wrap) begin
        reversing = 1'b1;
        cur_slot  = span_eff - 1;
      end else begin
        cur_slot = 0;
      end
    end
    if (cur_slot == 0) reversing = 1'b0;
  endfunction

  // expected output pixel for one accepted sample, updating the shadow store
  function automatic pixel_res_t blend_pixel(pixel_req_t px);
    pixel_res_t res;
    logic [fbob_pkg::SAMPLE_W-1:0] stored;
    logic [fbob_pkg::SAMPLE_W-1:0] wr_val;
    int   addr;
    int   mix;
    logic do_write;
    res.sample    = px.sample;
    res.plane     = px.plane;
    res.frame_end = px.frame_end;
    do_write      = 1'b0;
    wr_val        = px.sample;
    if (px.plane == fbob_pkg::PLANE_Y) begin
      addr = cur_slot * fbob_pkg::LUMA_PIXELS_DEF
           + int'(px.position) % fbob_pkg::LUMA_PIXELS_DEF;
    end else begin
      addr = cur_slot * CHROMA_PIXELS + int'(px.position) % CHROMA_PIXELS;
    end
    if (px.plane != PLANE_NONE) begin
      case (px.plane)
        fbob_pkg::PLANE_Y: stored = luma_mem[addr];
        fbob_pkg::PLANE_U: stored = cb_mem[addr];
        default:           stored = cr_mem[addr];
      endcase
      if (cur_slot == 0) begin
        do_write = 1'b1;
      end else begin
        mix = ((int'(fbob_pkg::FULL_SCALE) - cur_opacity) * int'(px.sample)
               + cur_opacity * int'(stored)) >> 8;
        if (!reversing) begin
          do_write   = 1'b1;
          wr_val     = mix[fbob_pkg::SAMPLE_W-1:0];
          res.sample = mix[fbob_pkg::SAMPLE_W-1:0];
          n_blends++;
        end else begin
          res.sample = stored;
          n_replays++;
        end
      end
      if (do_write) begin
        case (px.plane)
          fbob_pkg::PLANE_Y: luma_mem[addr] = wr_val;
          fbob_pkg::PLANE_U: cb_mem[addr]   = wr_val;
          default:           cr_mem[addr]   = wr_val;
        endcase
      end
    end
    if (px.frame_end) begin
      advance_slot();
      n_frame_ends++;
    end
    return res;
  endfunction

  // sample driver: random gap before each request, hold while stalled
  int gap_left;
  pixel_req_t cur_px;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      gap_left = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_pixels.push_back(blend_pixel(cur_px));
        n_accepted++;
        gap_left = $urandom_range(0, sender_idle_max);
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (send_pixels.size() != 0) begin
          cur_px = send_pixels.pop_front();
          s_axis_tdata  <= {4'b0, cur_px.sample, cur_px.position};
          s_axis_tuser  <= cur_px.plane;
          s_axis_tlast  <= cur_px.frame_end;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor: random stall after each result, field by field compare
  int stall_left;
  pixel_res_t want;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        if (expected_pixels.size() == 0) begin
          n_errors++;
          $error("unexpected result: out_sample %0d out_plane %0d out_frame_end %0d",
                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end else begin
          want = expected_pixels.pop_front();
          if (m_axis_tdata[fbob_pkg::SAMPLE_W-1:0] !== want.sample) begin
            n_errors++;
            $error("out_sample: expected %0d, got %0d", want.sample, m_axis_tdata);
          end
          if (m_axis_tuser !== want.plane) begin
            n_errors++;
            $error("out_plane: expected %0d, got %0d", want.plane, m_axis_tuser);
          end
          if (m_axis_tlast !== want.frame_end) begin
            n_errors++;
            $error("out_frame_end: expected %0d, got %0d", want.frame_end, m_axis_tlast);
          end
        end
        stall_left = $urandom_range(0, sink_stall_max);
      end
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  function automatic void queue_pixel(logic [fbob_pkg::PLANE_W-1:0] plane, int position,
                                      int sample, logic frame_end);
    pixel_req_t px;
    px.plane     = plane;
    px.position  = position[fbob_pkg::POS_W-1:0];
    px.sample    = sample[fbob_pkg::SAMPLE_W-1:0];
    px.frame_end = frame_end;
    send_pixels.push_back(px);
    n_queued++;
  endfunction

  // short frames over a small position pool so stored pixels get revisited
  function automatic void queue_frames(int count);
    int made;
    int len;
    int pick;
    int pos;
    logic [fbob_pkg::PLANE_W-1:0] plane;
    made = 0;
    while (made < count) begin
      len = $urandom_range(1, 8);
      for (int k = 0; k < len; k++) begin
        pick = $urandom_range(0, 15);
        if (pick <= 7)       plane = fbob_pkg::PLANE_Y;
        else if (pick <= 11) plane = fbob_pkg::PLANE_U;
        else if (pick <= 14) plane = fbob_pkg::PLANE_V;
        else                 plane = PLANE_NONE;
        if ($urandom_range(0, 9) < 7) pos = $urandom_range(0, 15) + ($urandom_range(0, 3) << 10);
        else                          pos = $urandom_range(0, 4095);
        queue_pixel(plane, pos, $urandom_range(0, 255), k == len - 1);
      end
      made += len;
    end
  endfunction

  // register write, called on a clock edge; valid is left high for the caller
  task automatic write_reg(logic [fbob_pkg::CFG_IDX_W-1:0] idx,
                           logic [fbob_pkg::CFG_DATA_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    n_cfg_writes++;
    case (idx)
      fbob_pkg::CFG_OPACITY: cur_opacity = int'(val);
      fbob_pkg::CFG_SPAN:    cur_span    = int'(val[fbob_pkg::SPAN_W-1:0]);
      fbob_pkg::CFG_WRAP:    cur_wrap    = val[0];
      default:               ;
    endcase
  endtask

  // hold off until every request has been answered and the pipeline is empty
  task automatic wait_drained();
    while (n_accepted != n_queued || expected_pixels.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic run_phase(int opacity, int span, int wrap, int count, int idle);
    write_reg(fbob_pkg::CFG_OPACITY, opacity[fbob_pkg::CFG_DATA_W-1:0]);
    write_reg(fbob_pkg::CFG_SPAN, span[fbob_pkg::CFG_DATA_W-1:0]);
    write_reg(fbob_pkg::CFG_WRAP, wrap[fbob_pkg::CFG_DATA_W-1:0]);
    cfg_valid_i <= 1'b0;
    sender_idle_max = idle;
    sink_stall_max  = idle;
    queue_frames(count);
    wait_drained();
  endtask

  // main sequence
  initial begin
    foreach (luma_mem[i]) luma_mem[i] = fbob_pkg::LUMA_BLACK;
    foreach (cb_mem[i])   cb_mem[i]   = fbob_pkg::CHROMA_MID;
    foreach (cr_mem[i])   cr_mem[i]   = fbob_pkg::CHROMA_MID;
    cur_slot        = 0;
    reversing       = 1'b0;
    cur_opacity     = int'(fbob_pkg::OPACITY_RST);
    cur_span        = int'(fbob_pkg::SPAN_RST);
    cur_wrap        = fbob_pkg::WRAP_RST;
    sender_idle_max = 4;
    sink_stall_max  = 4;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, aliased chroma positions, unused plane,
    // slot zero capture then blends against the cleared frames
    queue_pixel(fbob_pkg::PLANE_Y, 0, 0, 1'b0);
    queue_pixel(fbob_pkg::PLANE_Y, 4095, 255, 1'b0);
    queue_pixel(fbob_pkg::PLANE_U, 0, 255, 1'b0);
    queue_pixel(fbob_pkg::PLANE_V, 1023, 0, 1'b0);
    queue_pixel(fbob_pkg::PLANE_U, 4095, 77, 1'b0);
    queue_pixel(fbob_pkg::PLANE_V, 2048, 200, 1'b0);
    queue_pixel(PLANE_NONE, 123, 99, 1'b0);
    queue_pixel(fbob_pkg::PLANE_Y, 5, 10, 1'b1);
    queue_pixel(fbob_pkg::PLANE_Y, 0, 255, 1'b0);
    queue_pixel(fbob_pkg::PLANE_Y, 4095, 0, 1'b0);
    queue_pixel(fbob_pkg::PLANE_U, 1023, 255, 1'b0);
    queue_pixel(fbob_pkg::PLANE_V, 3071, 0, 1'b0);
    queue_pixel(PLANE_NONE, 4095, 200, 1'b1);
    queue_pixel(fbob_pkg::PLANE_Y, 7, 128, 1'b0);
    queue_pixel(fbob_pkg::PLANE_V, 7, 1, 1'b1);
    queue_pixel(fbob_pkg::PLANE_Y, 4095, 255, 1'b1);
    wait_drained();

    // register settings, extremes first; zero span acts as one
    run_phase(0, 1, 0, 160, 4);
    run_phase(255, 15, 0, 170, 0);
    run_phase(0, 0, 1, 150, 4);
    run_phase(128, 3, 0, 160, 4);
    run_phase(255, 2, 1, 150, 0);
    run_phase($urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(0, 1), 160, 4);
    run_phase($urandom_range(0, 255), $urandom_range(0, 15), $urandom_range(0, 1), 160, 2);
    write_reg(CFG_NONE, 8'hA5);
    run_phase(150, 4, 0, 160, 4);

    $display("covered %0d samples (%0d blended, %0d replayed), %0d frame ends,",
             n_accepted, n_blends, n_replays, n_frame_ends);
    $display("  %0d register writes, %0d results checked", n_cfg_writes, n_results);
    if (n_errors == 0) begin
      $display("tb_frame_bounce_overlay_blend: clean");
    end else begin
      $display("tb_frame_bounce_overlay_blend: errors");
    end
    $finish;
  end

  // watchdog, well past the store clear and the slowest stall pattern
  initial begin
    #6_000_000;
    $display("timeout after %0d of %0d samples", n_accepted, n_queued);
    $display("tb_frame_bounce_overlay_blend: errors");
    $finish;
  end

endmodule
